@@ hdl/drlc_pkg.sv @@
// shared types and constants for the domain report length checker
// no dependencies; imported by every module under hdl
`default_nettype none

package drlc_pkg;

  localparam int INDEX_WIDTH_DEF = 16;
  localparam int WORD_W          = 16;
  localparam int REND_W          = 15;
  localparam int POS_W           = 17;
  localparam int FIRST_PATH      = 4;
  localparam logic [7:0] LEN_BYTE_MASK = 8'hff;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERRUN = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } item_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/domain_report_length_checker.sv @@
// Domain report length checker, top level.
// Input channel: one 16-bit report word per transfer (in_word), with in_last
// marking the final word of the stream; a transfer happens when in_valid is
// high and in_stall is low. The first word is the byte length of the report,
// words 1 to 3 are header, then paths and their elements follow.
// Output channel: exactly one 2-bit status per stream, for the marked word:
// 0 valid, 1 a path or element overruns its bound, 2 stream shorter than the
// declared length. Transfers when out_valid is high and out_stall is low.
// Throughput: one word per clock while no marked word is waiting for the
// result register; the bound registers are updated from the input register.
// The marked word passes through the input register, then its status is
// captured in the result register, where the receiver takes it.
// Stalls: non-marked words keep flowing while a status waits; a marked word
// waits in the input register until the result register is free.
// Reset: rst_n is synchronous, active low; it empties both registers and
// returns the check state to the start of a report, as does every marked word.
// Depends on drlc_pkg, drlc_in_reg, drlc_check, drlc_out_reg.
`default_nettype none

module domain_report_length_checker #(
  parameter int INDEX_WIDTH = drlc_pkg::INDEX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_word,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status
);
  import drlc_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  take;
  logic  out_free;
  res_t  res;

  assign in_item.word = in_word;
  assign in_item.last = in_last;

  // a marked word needs room in the result register, other words never wait
  assign take = s1_valid && (!s1_item.last || out_free);

  drlc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  drlc_check #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (take),
    .item  (s1_item),
    .res   (res)
  );

  drlc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status)
  );

  a_status_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("status produced while result register is full");

endmodule

`default_nettype wire

@@ hdl/drlc_in_reg.sv @@
// input register stage: captures one report word and its last mark
// depends on drlc_pkg
`default_nettype none

module drlc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  drlc_pkg::item_t in_item,
  input  logic            take,
  output logic            s1_valid,
  output drlc_pkg::item_t s1_item
);
  import drlc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // the stage can refill whenever it is empty or its word moves on this cycle
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

@@ hdl/drlc_check.sv @@
// length check state: word counter, report/path/element bounds, sticky overrun
// depends on drlc_pkg
`default_nettype none

module drlc_check #(
  parameter int INDEX_WIDTH = drlc_pkg::INDEX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            proc,
  input  drlc_pkg::item_t item,
  output drlc_pkg::res_t  res
);
  import drlc_pkg::*;

  localparam int EXT_W = (INDEX_WIDTH > POS_W) ? INDEX_WIDTH : POS_W;

  logic [INDEX_WIDTH-1:0] idx_r, idx_nxt;
  logic [REND_W-1:0]      rend_r, rend_nxt;
  logic [POS_W-1:0]       pend_r, pend_nxt;
  logic [POS_W-1:0]       npath_r, npath_nxt;
  logic [POS_W-1:0]       nelem_r, nelem_nxt;
  logic                   ovr_r, ovr_nxt;

  logic [EXT_W-1:0] idx_ext;
  logic [POS_W-1:0] i17;
  logic             idx_max;
  logic             in_body;
  logic             path_hit;
  logic             elem_hit;
  logic [POS_W:0]   path_sum;
  logic [8:0]       elem_round;
  logic [7:0]       elem_words;
  logic [POS_W:0]   elem_sum;
  logic             path_ovr;
  logic             elem_ovr;

  assign idx_ext  = EXT_W'(idx_r);
  assign i17      = idx_ext[POS_W-1:0];
  assign idx_max  = &idx_r;
  assign in_body  = (idx_ext >= EXT_W'(FIRST_PATH)) && (idx_ext <= EXT_W'(rend_r)) && !ovr_r;
  assign path_hit = (idx_ext == EXT_W'(npath_r));
  assign elem_hit = (idx_ext == EXT_W'(nelem_r)) && (idx_ext <= EXT_W'(pend_r));

  // path length in bytes halved; element length in low byte rounded up to words
  assign path_sum   = {1'b0, i17} + (POS_W+1)'(item.word[WORD_W-1:1]);
  assign elem_round = {1'b0, item.word[7:0] & LEN_BYTE_MASK} + 9'd1;
  assign elem_words = elem_round[8:1];
  assign elem_sum   = {1'b0, i17} + (POS_W+1)'(elem_words);
  assign path_ovr   = path_sum > (POS_W+1)'(rend_r);
  assign elem_ovr   = elem_sum > (POS_W+1)'(pend_r);

  always_comb begin
    idx_nxt   = idx_r;
    rend_nxt  = rend_r;
    pend_nxt  = pend_r;
    npath_nxt = npath_r;
    nelem_nxt = nelem_r;
    ovr_nxt   = ovr_r;
    if (proc && !idx_max) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == '0) begin
        rend_nxt = item.word[WORD_W-1:1];
      end else if (in_body) begin
        if (path_hit) begin
          if (path_ovr) begin
            ovr_nxt = 1'b1;
          end else begin
            pend_nxt  = path_sum[POS_W-1:0];
            nelem_nxt = i17 + 1'b1;
            npath_nxt = path_sum[POS_W-1:0] + 1'b1;
          end
        end else if (elem_hit) begin
          if (elem_ovr) begin
            ovr_nxt = 1'b1;
          end else begin
            nelem_nxt = elem_sum[POS_W-1:0] + 1'b1;
          end
        end
      end
    end

    res.valid  = proc && item.last;
    if (ovr_nxt) begin
      res.status = ST_OVERRUN;
    end else if (idx_ext < EXT_W'(rend_nxt)) begin
      res.status = ST_SHORT;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proc && item.last)) begin
      idx_r   <= '0;
      rend_r  <= '0;
      pend_r  <= '0;
      npath_r <= POS_W'(FIRST_PATH);
      nelem_r <= '0;
      ovr_r   <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      rend_r  <= rend_nxt;
      pend_r  <= pend_nxt;
      npath_r <= npath_nxt;
      nelem_r <= nelem_nxt;
      ovr_r   <= ovr_nxt;
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    proc && item.last |=> (idx_r == '0) && !ovr_r && (npath_r == POS_W'(FIRST_PATH)))
    else $error("report state not restarted after last word");

  a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovr_r && !(proc && item.last) |=> ovr_r)
    else $error("overrun flag dropped inside a report");

  a_rend_only_at_head: assert property (@(posedge clk) disable iff (!rst_n)
    !(proc && ((idx_r == '0) || item.last)) |=> $stable(rend_r))
    else $error("report end changed away from the length word");

  a_counter_holds_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    idx_max && !(proc && item.last) |=> idx_max)
    else $error("saturated word counter moved");

endmodule

`default_nettype wire

@@ hdl/drlc_out_reg.sv @@
// result register: holds one status word until the receiver takes it
// depends on drlc_pkg
`default_nettype none

module drlc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  drlc_pkg::res_t    res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status
);
  import drlc_pkg::*;

  logic    valid_r, valid_nxt;
  status_t status_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = out_free ? res.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      status_r <= res.status;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule

`default_nettype wire

@@ sim/domain_report_length_checker_tb.sv @@
// testbench for domain_report_length_checker: drives report words, predicts statuses
// depends on drlc_pkg and the domain_report_length_checker top level under hdl
`default_nettype none

module domain_report_length_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drlc_pkg::*;

  localparam longint unsigned IDX_MAX = (64'd1 << INDEX_WIDTH_DEF) - 1;
  localparam int IDLE_PCT = 18;
  localparam int RANDOM_WORDS = 1800;

  typedef enum int {
    SHAPE_CLEAN,
    SHAPE_TAIL,
    SHAPE_CUT,
    SHAPE_BENT
  } shape_t;

  // running walk of the nested lengths, and the statuses still owed by the block
  class report_status_board;
    longint unsigned idx, rep_end, path_last, path_next, elem_next;
    bit overrun;
    status_t status_due[$];
    int mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      idx = 0;
      rep_end = 0;
      path_last = 0;
      path_next = FIRST_PATH;
      elem_next = 0;
      overrun = 1'b0;
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: %s, expected %0d, actual %0d", what, want, got);
    endfunction

    function void walk_word(longint unsigned i, logic [15:0] w);
      longint unsigned span;
      if (i == 0) begin
        rep_end = longint'(w >> 1) & 64'h7fff;
        return;
      end
      if (i < FIRST_PATH || i > rep_end || overrun)
        return;
      if (i == path_next) begin
        span = longint'(w >> 1);
        if (i + span > rep_end) begin
          overrun = 1'b1;
          return;
        end
        path_last = (i + span) & 64'h1ffff;
        elem_next = (i + 1) & 64'h1ffff;
        path_next = (i + span + 1) & 64'h1ffff;
      end else if (i == elem_next && i <= path_last) begin
        // element length sits in the low byte, rounded up to whole words
        span = (longint'(w & LEN_BYTE_MASK) + 1) >> 1;
        if (i + span > path_last) begin
          overrun = 1'b1;
          return;
        end
        elem_next = (i + span + 1) & 64'h1ffff;
      end
    endfunction

    function void take_word(logic [15:0] w, logic lst);
      longint unsigned i;
      i = idx;
      if (i < IDX_MAX) begin
        walk_word(i, w);
        idx = i + 1;
      end
      if (lst) begin
        if (overrun)
          status_due.push_back(ST_OVERRUN);
        else if (i < rep_end)
          status_due.push_back(ST_SHORT);
        else
          status_due.push_back(ST_OK);
        restart();
      end
    endfunction

    function void check_status(logic [1:0] got);
      status_t want;
      if (status_due.size() == 0) begin
        flag("status with no report pending", -1, got);
        return;
      end
      want = status_due.pop_front();
      if (got !== want)
        flag("out_status", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_word = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;

  report_status_board board = new();
  item_t report_q[$];
  bit steady = 1'b0;
  int unsigned words_sent = 0;

  domain_report_length_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_status(out_status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.take_word(in_word, in_last);
    if (rst_n && out_valid && !out_stall)
      board.check_status(out_status);
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(logic [15:0] w, logic lst);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    in_last <= lst;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put(logic [15:0] w, logic lst);
    report_q.push_back('{word: w, last: lst});
  endtask

  task automatic send_queued();
    foreach (report_q[k])
      send_word(report_q[k].word, report_q[k].last);
    report_q.delete();
  endtask

  // lays out a report whose paths and elements fill it exactly, then mangles it unless the shape is clean
  task automatic build_report(int unsigned rend, shape_t shape, int unsigned tail_n);
    logic [15:0] img[$];
    int unsigned i, j, pw, ew, lim, k;
    logic [7:0] b;
    img.push_back({rend[14:0], 1'($urandom_range(1))});
    repeat (3) img.push_back(16'($urandom));
    i = FIRST_PATH;
    while (i <= rend) begin
      if ($urandom_range(3) == 0)
        pw = $urandom_range(rend - i, 0);
      else
        pw = $urandom_range((rend - i > 12) ? 12 : rend - i, 0);
      img.push_back({pw[14:0], 1'($urandom_range(1))});
      j = i + 1;
      while (j <= i + pw) begin
        lim = (i + pw - j > 127) ? 127 : i + pw - j;
        ew = $urandom_range(lim, 0);
        b = (ew == 0) ? 8'd0 : 8'(2 * ew - $urandom_range(1));
        img.push_back({8'($urandom), b});
        repeat (ew) img.push_back(16'($urandom));
        j += ew + 1;
      end
      i += pw + 1;
    end
    case (shape)
      SHAPE_TAIL: begin
        repeat (tail_n) img.push_back(16'($urandom));
      end
      SHAPE_CUT: begin
        if (img.size() > 1) begin
          k = $urandom_range(img.size() - 1, 1);
          while (img.size() > k)
            void'(img.pop_back());
        end
      end
      SHAPE_BENT: begin
        k = $urandom_range(img.size() - 1, 0);
        if ($urandom_range(1))
          img[k] = 16'($urandom);
        else
          img[k] = img[k] ^ (16'd1 << $urandom_range(15));
      end
      default: ;
    endcase
    foreach (img[n])
      put(img[n], n == img.size() - 1);
  endtask

  initial begin
    int unsigned pick, rend, n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-word reports: zero length, and a length the stream never reaches
    put(16'h0000, 1'b1);
    put(16'hffff, 1'b1);
    // length word too short to hold any path
    put(16'd7, 1'b0);
    put(16'h1234, 1'b0);
    put(16'hedcb, 1'b0);
    put(16'h8001, 1'b1);
    // empty path
    put(16'd8, 1'b0);
    repeat (3) put(16'h5a5a, 1'b0);
    put(16'h0001, 1'b1);
    // path runs past the report end
    put(16'd12, 1'b0);
    repeat (3) put(16'ha5a5, 1'b0);
    put(16'h000a, 1'b0);
    put(16'h0000, 1'b1);
    // element runs past its path end
    put(16'd14, 1'b0);
    repeat (3) put(16'hffff, 1'b0);
    put(16'h0006, 1'b0);
    put(16'hab07, 1'b0);
    put(16'h0000, 1'b1);
    // overrun, then the stream ends short
    put(16'd40, 1'b0);
    repeat (3) put(16'h0000, 1'b0);
    put(16'hfffe, 1'b0);
    put(16'h0000, 1'b1);
    // largest element, 0xff bytes, exactly filling its path
    put(16'd266, 1'b0);
    repeat (3) put(16'h0f0f, 1'b0);
    put(16'd258, 1'b0);
    put(16'h00ff, 1'b0);
    for (int m = 0; m < 128; m++)
      put(16'($urandom), m == 127);
    send_queued();
    build_report(10, SHAPE_TAIL, 4);
    build_report(30, SHAPE_CUT, 0);
    send_queued();

    n = words_sent;
    while (words_sent - n < RANDOM_WORDS) begin
      steady = (words_sent - n > 800) && (words_sent - n < 1150);
      pick = $urandom_range(99);
      rend = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(40);
      if (pick < 45)
        build_report(rend, SHAPE_CLEAN, 0);
      else if (pick < 55)
        build_report(rend, SHAPE_TAIL, $urandom_range(6, 1));
      else if (pick < 67)
        build_report(rend, SHAPE_CUT, 0);
      else if (pick < 88)
        build_report(rend, SHAPE_BENT, 0);
      else begin
        // raw noise words
        pick = $urandom_range(20, 1);
        for (int m = 0; m < pick; m++)
          put(16'($urandom), m == pick - 1);
      end
      send_queued();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (board.status_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.status_due.size() != 0)
      board.flag("statuses never delivered", board.status_due.size(), 0);
    if (board.mismatches == 0)
      $display("domain_report_length_checker_tb: clean");
    else
      $display("domain_report_length_checker_tb: errors");
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("domain_report_length_checker_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

@@ domain_report_length_checker.f @@
hdl/drlc_pkg.sv
hdl/drlc_in_reg.sv
hdl/drlc_check.sv
hdl/drlc_out_reg.sv
hdl/domain_report_length_checker.sv
sim/domain_report_length_checker_tb.sv
